// ===== hdl/lasprd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lasprd_pkg: shared types and constants
// Widths, register indexes and the record entry passed from front to back.
// ----------------------------------------------------------------------------
package lasprd_pkg;

   localparam int COORD_BYTES   = 12;
   localparam int COORD_LANES   = 3;
   localparam int RAW_W         = 32;
   localparam int SCALE_W       = 32;
   localparam int OFFSET_W      = 56;
   localparam int COORD_W       = 64;
   localparam int LEN_W         = 16;
   localparam int COUNT_W       = 32;
   localparam int BYTE_W        = 8;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 64;
   localparam int RSP_DATA_W    = COORD_LANES * COORD_W;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [LEN_W-1:0]    RECORD_LENGTH_RST = 16'd20;
   localparam logic [COUNT_W-1:0]  POINT_TOTAL_RST   = 32'd1;
   localparam logic [SCALE_W-1:0]  SCALE_RST         = 32'd16777216;
   localparam logic [OFFSET_W-1:0] OFFSET_RST        = '0;
   localparam logic [LEN_W-1:0]    COORD_BYTES_LEN   = LEN_W'(COORD_BYTES);

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RECORD_LENGTH = 4'd0,
      REG_POINT_TOTAL   = 4'd1,
      REG_SCALE_X       = 4'd2,
      REG_SCALE_Y       = 4'd3,
      REG_SCALE_Z       = 4'd4,
      REG_OFFSET_X      = 4'd5,
      REG_OFFSET_Y      = 4'd6,
      REG_OFFSET_Z      = 4'd7
   } lasprd_reg_type;

   typedef struct packed {
      logic                                   last_point;
      logic [COORD_LANES-1:0][RAW_W-1:0]      raw;
   } lasprd_rec_type;

   typedef struct packed {
      logic [COORD_LANES-1:0][SCALE_W-1:0]    scale;
      logic [COORD_LANES-1:0][OFFSET_W-1:0]   offset;
   } lasprd_xform_type;

endpackage
`default_nettype wire

// ===== hdl/lasprd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lasprd_front: byte assembly and record framing
// Tracks position in the record, captures the coordinate bytes and pushes one
// entry per record with its last-point mark.
// ----------------------------------------------------------------------------
module lasprd_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  byte_valid,
   output logic                                 byte_ready,
   input  wire [lasprd_pkg::BYTE_W-1:0]         data_byte,
   input  wire [lasprd_pkg::LEN_W-1:0]          record_length,
   input  wire [lasprd_pkg::COUNT_W-1:0]        point_total,
   output logic                                 push_valid,
   input  wire                                  push_ready,
   output lasprd_pkg::lasprd_rec_type           push_rec
);
   import lasprd_pkg::*;

   logic [LEN_W-1:0]                   pos_ff, pos_in;
   logic [COUNT_W-1:0]                 count_ff, count_in;
   logic [COORD_BYTES-1:0][BYTE_W-1:0] raw_ff, raw_in;
   logic [LEN_W-1:0]                   len_eff;
   logic                               take;
   logic                               rec_end;
   logic                               is_last;

   assign byte_ready = push_ready;
   assign take       = byte_valid && push_ready;
   assign len_eff    = (record_length < COORD_BYTES_LEN) ? COORD_BYTES_LEN : record_length;
   assign rec_end    = pos_ff >= (len_eff - LEN_W'(1));
   assign is_last    = ({1'b0, count_ff} + (COUNT_W+1)'(1)) >= {1'b0, point_total};

   always_comb begin
      raw_in = raw_ff;
      if (pos_ff < COORD_BYTES_LEN) begin
         raw_in[pos_ff[$clog2(COORD_BYTES)-1:0]] = data_byte;
      end
      pos_in   = rec_end ? '0 : pos_ff + LEN_W'(1);
      count_in = (rec_end && is_last) ? '0 : (rec_end ? count_ff + COUNT_W'(1) : count_ff);
   end

   assign push_valid          = take && rec_end;
   assign push_rec.last_point = is_last;
   assign push_rec.raw        = raw_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         raw_ff   <= '0;
      end else if (take) begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         raw_ff   <= raw_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/lasprd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lasprd_queue: record queue
// Small first-in first-out store of record entries between front and back.
// ----------------------------------------------------------------------------
module lasprd_queue #(
   parameter int DEPTH = lasprd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push_valid,
   output logic                        push_ready,
   input  lasprd_pkg::lasprd_rec_type  push_rec,
   output logic                        pop_valid,
   input  wire                         pop_ready,
   output lasprd_pkg::lasprd_rec_type  pop_rec
);
   import lasprd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0]   FULL_COUNT = (AW+1)'(DEPTH);
   localparam logic [AW-1:0] LAST_PTR   = AW'(DEPTH - 1);

   lasprd_rec_type       entry_ff [DEPTH];
   logic [AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [AW:0]          fill_ff, fill_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = fill_ff != FULL_COUNT;
   assign pop_valid  = fill_ff != '0;
   assign pop_rec    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/lasprd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lasprd_back: scale and offset pipeline
// Stage one multiplies raw values by their scales, stage two adds the offsets
// with saturation into the output register.
// ----------------------------------------------------------------------------
module lasprd_back (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          rec_valid,
   output logic                                         rec_ready,
   input  lasprd_pkg::lasprd_rec_type                   rec,
   input  lasprd_pkg::lasprd_xform_type                 xform,
   output logic                                         out_valid,
   input  wire                                          out_ready,
   output logic [lasprd_pkg::COORD_LANES-1:0][lasprd_pkg::COORD_W-1:0] out_coord,
   output logic                                         out_last,
   output logic                                         out_sat
);
   import lasprd_pkg::*;

   logic                                     s1_valid_ff;
   logic                                     s1_last_ff;
   logic [COORD_LANES-1:0][COORD_W-1:0]      prod_ff, prod_in;
   logic                                     s2_valid_ff;
   logic                                     s2_last_ff;
   logic                                     s2_sat_ff, s2_sat_in;
   logic [COORD_LANES-1:0][COORD_W-1:0]      coord_ff, coord_in;
   logic                                     s2_load;
   logic                                     s1_load;
   logic signed [RAW_W+SCALE_W+1:0]          mul [COORD_LANES];
   logic signed [COORD_W:0]                  sum [COORD_LANES];

   assign s2_load   = !s2_valid_ff || out_ready;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign rec_ready = s1_load;

   always_comb begin
      for (int i = 0; i < COORD_LANES; i++) begin
         mul[i]     = $signed(rec.raw[i]) * $signed({1'b0, xform.scale[i]});
         prod_in[i] = mul[i][COORD_W-1:0];
      end
   end

   always_comb begin
      s2_sat_in = 1'b0;
      for (int i = 0; i < COORD_LANES; i++) begin
         sum[i] = $signed({prod_ff[i][COORD_W-1], prod_ff[i]})
                + $signed({{(COORD_W+1-OFFSET_W){xform.offset[i][OFFSET_W-1]}},
                           xform.offset[i]});
         if (sum[i][COORD_W] != sum[i][COORD_W-1]) begin
            s2_sat_in   = 1'b1;
            coord_in[i] = sum[i][COORD_W] ? COORD_MIN : COORD_MAX;
         end else begin
            coord_in[i] = sum[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         prod_ff    <= prod_in;
         s1_last_ff <= rec.last_point;
      end
      if (s2_load) begin
         coord_ff   <= coord_in;
         s2_sat_ff  <= s2_sat_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= rec_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_coord = coord_ff;
   assign out_last  = s2_last_ff;
   assign out_sat   = s2_sat_ff;

endmodule
`default_nettype wire

// ===== hdl/las_point_record_decoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// las_point_record_decoder_core: LAS point record XYZ decoder
// Turns the point-data byte stream into scaled, offset Q40.24 coordinates.
//
//  channel   direction  width  content
//  req_      in         8      data_byte
//  rsp_      out        192+2  coord_x, coord_y, coord_z; tlast last_point;
//                              tuser saturated
//  csr_      in         4+64   register index, write data
//
// One byte is taken per cycle while the record queue has room; the front reads
// nothing but the record queue full flag. Once the last byte of a record is
// taken, its entry passes the queue write, the multiply stage and the
// offset/saturate stage before rsp_tvalid rises. The back drains one record
// per cycle while rsp_ is not stalled; a stalled rsp_ fills the queue before
// req_tready drops.
// Reset is synchronous and sets the registers to defaults; no clearing pass.
// ----------------------------------------------------------------------------
module las_point_record_decoder_core #(
   parameter int QUEUE_DEPTH = lasprd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire [lasprd_pkg::BYTE_W-1:0]          req_tdata,   // [7:0] data_byte
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // [63:0] coord_x, [127:64] coord_y, [191:128] coord_z
   output logic [lasprd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser,   // [0] saturated
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [lasprd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [lasprd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import lasprd_pkg::*;

   logic [LEN_W-1:0]   record_length_ff;
   logic [COUNT_W-1:0] point_total_ff;
   lasprd_xform_type   xform_ff;
   logic               push_valid;
   logic               push_ready;
   lasprd_rec_type     push_rec;
   logic               pop_valid;
   logic               pop_ready;
   lasprd_rec_type     pop_rec;
   logic [COORD_LANES-1:0][COORD_W-1:0] coord;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_length_ff <= RECORD_LENGTH_RST;
         point_total_ff   <= POINT_TOTAL_RST;
         xform_ff.scale   <= {COORD_LANES{SCALE_RST}};
         xform_ff.offset  <= {COORD_LANES{OFFSET_RST}};
      end else if (csr_valid) begin
         unique case (lasprd_reg_type'(csr_index))
            REG_RECORD_LENGTH: record_length_ff   <= csr_data[LEN_W-1:0];
            REG_POINT_TOTAL:   point_total_ff     <= csr_data[COUNT_W-1:0];
            REG_SCALE_X:       xform_ff.scale[0]  <= csr_data[SCALE_W-1:0];
            REG_SCALE_Y:       xform_ff.scale[1]  <= csr_data[SCALE_W-1:0];
            REG_SCALE_Z:       xform_ff.scale[2]  <= csr_data[SCALE_W-1:0];
            REG_OFFSET_X:      xform_ff.offset[0] <= csr_data[OFFSET_W-1:0];
            REG_OFFSET_Y:      xform_ff.offset[1] <= csr_data[OFFSET_W-1:0];
            REG_OFFSET_Z:      xform_ff.offset[2] <= csr_data[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   lasprd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .byte_valid    (req_tvalid),
      .byte_ready    (req_tready),
      .data_byte     (req_tdata),
      .record_length (record_length_ff),
      .point_total   (point_total_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_rec      (push_rec)
   );

   lasprd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   lasprd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (pop_valid),
      .rec_ready (pop_ready),
      .rec       (pop_rec),
      .xform     (xform_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_coord (coord),
      .out_last  (rsp_tlast),
      .out_sat   (rsp_tuser)
   );

   assign rsp_tdata = coord;

endmodule
`default_nettype wire

// ===== hdl/lasprd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lasprd_checker: port-level checks
// Watches the decoder's ports; bound to the top level below.
// ----------------------------------------------------------------------------
module lasprd_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 rsp_tvalid,
   input wire                                 rsp_tready,
   input wire [lasprd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire                                 rsp_tlast,
   input wire                                 rsp_tuser
);
   import lasprd_pkg::*;

   logic sat_at_bound;

   assign sat_at_bound =
      (rsp_tdata[63:0] == COORD_MAX)    || (rsp_tdata[63:0] == COORD_MIN)    ||
      (rsp_tdata[127:64] == COORD_MAX)  || (rsp_tdata[127:64] == COORD_MIN)  ||
      (rsp_tdata[191:128] == COORD_MAX) || (rsp_tdata[191:128] == COORD_MIN);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> sat_at_bound)
      else $error("saturated flag without a clamped coordinate");

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         ($stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("result changed while stalled");

endmodule

bind las_point_record_decoder_core lasprd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
